// ===== hw/rtl/hles_pkg.sv =====
`default_nettype none
package hles_pkg;

   // Field widths fixed by the item format.
   localparam int VAL_W    = 32;
   localparam int TIME_W   = 24;
   localparam int HL_W     = 32;
   localparam int ROOT_MAX = 24;
   localparam logic [HL_W-1:0] HL_RESET = 32'd65536;

   typedef logic signed [VAL_W-1:0] coord_type;

   // Current and target point carried alongside the decay computation.
   typedef struct packed {
      coord_type cur_x;
      coord_type cur_y;
      coord_type cur_z;
      coord_type tgt_x;
      coord_type tgt_y;
      coord_type tgt_z;
   } vec_pair_type;

   // Floor square root, evaluated only at elaboration.
   function automatic logic [63:0] isqrt64(input logic [63:0] x);
      logic [63:0] rem;
      logic [63:0] res;
      logic [63:0] bit_v;
      rem = x;
      res = '0;
      for (int i = 31; i >= 0; i--) begin
         bit_v = 64'd1 << (2 * i);
         if (rem >= res + bit_v) begin
            rem = rem - (res + bit_v);
            res = (res >> 1) + bit_v;
         end else begin
            res = res >> 1;
         end
      end
      return res;
   endfunction

   // Q0.32 roots of one half: entry k-1 is close to 2^(-2^-k).
   function automatic logic [ROOT_MAX*32-1:0] root_table();
      logic [ROOT_MAX*32-1:0] t;
      logic [63:0] c;
      t = '0;
      c = 64'd1 << 31;
      for (int k = 0; k < ROOT_MAX; k++) begin
         c = isqrt64(c << 32);
         t[k*32 +: 32] = c[31:0];
      end
      return t;
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/hles_req_if.sv =====
`default_nettype none
interface hles_req_if;
   logic                valid;
   logic                ready;
   logic signed [31:0]  current_x;
   logic signed [31:0]  current_y;
   logic signed [31:0]  current_z;
   logic signed [31:0]  target_x;
   logic signed [31:0]  target_y;
   logic signed [31:0]  target_z;
   logic [23:0]         elapsed;

   modport source (output valid, current_x, current_y, current_z,
                   output target_x, target_y, target_z, elapsed, input ready);
   modport sink (input valid, current_x, current_y, current_z,
                 input target_x, target_y, target_z, elapsed, output ready);
endinterface

interface hles_rsp_if;
   logic                valid;
   logic                ready;
   logic signed [31:0]  out_x;
   logic signed [31:0]  out_y;
   logic signed [31:0]  out_z;

   modport source (output valid, out_x, out_y, out_z, input ready);
   modport sink (input valid, out_x, out_y, out_z, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/hles_div.sv =====
`default_nettype none
module hles_div
   import hles_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          advance,
   input  wire logic                          in_valid,
   input  wire logic [TIME_W-1:0]             in_elapsed,
   input  wire logic [HL_W-1:0]               period,
   input  wire vec_pair_type                  in_side,
   output logic                               out_valid,
   output logic [TIME_W+FRAC_BITS-1:0]        out_quo,
   output vec_pair_type                       out_side
);
   localparam int QW = TIME_W + FRAC_BITS;

   logic                valid_ff [QW];
   logic [HL_W-1:0]     rem_ff   [QW];
   logic [QW-1:0]       num_ff   [QW];
   logic [QW-1:0]       quo_ff   [QW];
   vec_pair_type        side_ff  [QW];

   logic                valid_in [QW];
   logic [HL_W-1:0]     rem_in   [QW];
   logic [QW-1:0]       num_in   [QW];
   logic [QW-1:0]       quo_in   [QW];
   vec_pair_type        side_in  [QW];

   logic [HL_W-1:0]     rem_prev [QW];
   logic [QW-1:0]       num_prev [QW];
   logic [QW-1:0]       quo_prev [QW];
   logic [HL_W:0]       trial    [QW];
   logic                take     [QW];

   // One quotient bit per stage: shift in the next dividend bit, subtract when it fits.
   always_comb begin
      for (int s = 0; s < QW; s++) begin
         if (s == 0) begin
            valid_in[s] = in_valid;
            rem_prev[s] = '0;
            num_prev[s] = {in_elapsed, {FRAC_BITS{1'b0}}};
            quo_prev[s] = '0;
            side_in[s]  = in_side;
         end else begin
            valid_in[s] = valid_ff[s-1];
            rem_prev[s] = rem_ff[s-1];
            num_prev[s] = num_ff[s-1];
            quo_prev[s] = quo_ff[s-1];
            side_in[s]  = side_ff[s-1];
         end
         trial[s] = {rem_prev[s], num_prev[s][QW-1]};
         take[s]  = trial[s] >= {1'b0, period};
         if (take[s]) begin
            rem_in[s] = HL_W'(trial[s] - {1'b0, period});
         end else begin
            rem_in[s] = trial[s][HL_W-1:0];
         end
         num_in[s] = {num_prev[s][QW-2:0], 1'b0};
         quo_in[s] = {quo_prev[s][QW-2:0], take[s]};
      end
   end

   // Stage registers move together on advance.
   always_ff @(posedge clock) begin
      for (int s = 0; s < QW; s++) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (advance) begin
            valid_ff[s] <= valid_in[s];
         end
         if (advance) begin
            rem_ff[s]  <= rem_in[s];
            num_ff[s]  <= num_in[s];
            quo_ff[s]  <= quo_in[s];
            side_ff[s] <= side_in[s];
         end
      end
   end

   assign out_valid = valid_ff[QW-1];
   assign out_quo   = quo_ff[QW-1];
   assign out_side  = side_ff[QW-1];
endmodule
`default_nettype wire

// ===== hw/rtl/hles_exp.sv =====
`default_nettype none
module hles_exp
   import hles_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          advance,
   input  wire logic                          in_valid,
   input  wire logic [TIME_W+FRAC_BITS-1:0]   in_quo,
   input  wire vec_pair_type                  in_side,
   output logic                               out_valid,
   output logic [FRAC_BITS:0]                 out_decay,
   output vec_pair_type                       out_side
);
   localparam int QW = TIME_W + FRAC_BITS;
   localparam logic [ROOT_MAX*32-1:0] ROOTS = root_table();

   logic                valid_ff [FRAC_BITS];
   logic [32:0]         acc_ff   [FRAC_BITS];
   logic [QW-1:0]       quo_ff   [FRAC_BITS];
   vec_pair_type        side_ff  [FRAC_BITS];

   logic                valid_in [FRAC_BITS];
   logic [32:0]         acc_in   [FRAC_BITS];
   logic [QW-1:0]       quo_in   [FRAC_BITS];
   vec_pair_type        side_in  [FRAC_BITS];
   logic [32:0]         acc_prev [FRAC_BITS];
   logic [64:0]         prod     [FRAC_BITS];

   logic                dec_valid_ff;
   logic [FRAC_BITS:0]  dec_ff;
   vec_pair_type        dec_side_ff;
   logic [FRAC_BITS:0]  dec_in;
   logic [TIME_W-1:0]   whole;
   logic [5:0]          shamt;
   logic [33:0]         rounded;

   // Stage k multiplies by the 2^(k+1)-th root of one half when fraction bit FRAC_BITS-1-k is set.
   always_comb begin
      for (int k = 0; k < FRAC_BITS; k++) begin
         if (k == 0) begin
            valid_in[k] = in_valid;
            acc_prev[k] = 33'h1_0000_0000;
            quo_in[k]   = in_quo;
            side_in[k]  = in_side;
         end else begin
            valid_in[k] = valid_ff[k-1];
            acc_prev[k] = acc_ff[k-1];
            quo_in[k]   = quo_ff[k-1];
            side_in[k]  = side_ff[k-1];
         end
         prod[k] = 65'(acc_prev[k]) * 65'(ROOTS[k*32 +: 32]) + 65'h8000_0000;
         if (quo_in[k][FRAC_BITS-1-k]) begin
            acc_in[k] = prod[k][64:32];
         end else begin
            acc_in[k] = acc_prev[k];
         end
      end
   end

   // Scale by the integer part: round and shift right, underflow to zero.
   always_comb begin
      whole   = quo_ff[FRAC_BITS-1][QW-1:FRAC_BITS];
      shamt   = 6'(32 - FRAC_BITS) + whole[5:0];
      rounded = ({1'b0, acc_ff[FRAC_BITS-1]} + (34'd1 << (shamt - 6'd1))) >> shamt;
      if (whole > TIME_W'(FRAC_BITS + 1)) begin
         dec_in = '0;
      end else begin
         dec_in = rounded[FRAC_BITS:0];
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < FRAC_BITS; k++) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (advance) begin
            valid_ff[k] <= valid_in[k];
         end
         if (advance) begin
            acc_ff[k]  <= acc_in[k];
            quo_ff[k]  <= quo_in[k];
            side_ff[k] <= side_in[k];
         end
      end
      if (reset) begin
         dec_valid_ff <= 1'b0;
      end else if (advance) begin
         dec_valid_ff <= valid_ff[FRAC_BITS-1];
      end
      if (advance) begin
         dec_ff      <= dec_in;
         dec_side_ff <= side_ff[FRAC_BITS-1];
      end
   end

   assign out_valid = dec_valid_ff;
   assign out_decay = dec_ff;
   assign out_side  = dec_side_ff;
endmodule
`default_nettype wire

// ===== hw/rtl/half_life_exponential_smoother.sv =====
// Channel   Direction  Transfer moves
// req_bus   in         current_x/y/z, target_x/y/z, elapsed
// rsp_bus   out        out_x/y/z
// csr_*     in         half-life register, written when csr_write_enable is high
//
// One vector enters per cycle while the output is not stalled; each result passes through
// the bit-per-stage divider, one root multiply per fraction bit, and the
// shift, blend multiply and round stages. Reset is synchronous and clears only
// valid bits and the half-life register (to 1.0 s). A stalled output freezes the
// whole pipeline, so no transfer is lost or repeated.
`default_nettype none
module half_life_exponential_smoother
   import hles_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   hles_req_if.sink              req_bus,
   hles_rsp_if.source            rsp_bus,
   input  wire logic             csr_write_enable,
   input  wire logic [HL_W-1:0]  csr_write_data
);
   localparam int QW = TIME_W + FRAC_BITS;
   localparam int PW = FRAC_BITS + 35;

   logic [HL_W-1:0]              period_ff;
   logic                         advance;
   vec_pair_type                 req_side;
   logic                         div_valid;
   logic [QW-1:0]                div_quo;
   vec_pair_type                 div_side;
   logic                         exp_valid;
   logic [FRAC_BITS:0]           exp_decay;
   vec_pair_type                 exp_side;

   coord_type                    cur   [3];
   coord_type                    tgt   [3];
   logic signed [32:0]           diff  [3];
   logic signed [FRAC_BITS+1:0]  dsgn;
   logic signed [PW-1:0]         p_in  [3];
   logic signed [PW-1:0]         p_ff  [3];
   coord_type                    tgt_ff [3];
   logic                         mul_valid_ff;
   logic signed [PW-1:0]         v_rnd [3];
   logic signed [PW-1:0]         q_rnd [3];
   coord_type                    out_in [3];
   coord_type                    out_ff [3];
   logic                         out_valid_ff;

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= HL_RESET;
      end else if (csr_write_enable) begin
         period_ff <= csr_write_data;
      end
   end

   // The pipeline moves unless a finished result is waiting.
   assign advance       = !out_valid_ff || rsp_bus.ready;
   assign req_bus.ready = advance;

   assign req_side = '{cur_x: req_bus.current_x, cur_y: req_bus.current_y,
                       cur_z: req_bus.current_z, tgt_x: req_bus.target_x,
                       tgt_y: req_bus.target_y, tgt_z: req_bus.target_z};

   hles_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .in_valid   (req_bus.valid),
      .in_elapsed (req_bus.elapsed),
      .period     (period_ff),
      .in_side    (req_side),
      .out_valid  (div_valid),
      .out_quo    (div_quo),
      .out_side   (div_side)
   );

   hles_exp #(.FRAC_BITS(FRAC_BITS)) u_exp (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (div_valid),
      .in_quo    (div_quo),
      .in_side   (div_side),
      .out_valid (exp_valid),
      .out_decay (exp_decay),
      .out_side  (exp_side)
   );

   // Blend multiply: (current - target) * decay per axis.
   always_comb begin
      cur[0] = exp_side.cur_x;
      cur[1] = exp_side.cur_y;
      cur[2] = exp_side.cur_z;
      tgt[0] = exp_side.tgt_x;
      tgt[1] = exp_side.tgt_y;
      tgt[2] = exp_side.tgt_z;
      dsgn   = $signed({1'b0, exp_decay});
      for (int a = 0; a < 3; a++) begin
         diff[a] = {cur[a][VAL_W-1], cur[a]} - {tgt[a][VAL_W-1], tgt[a]};
         p_in[a] = diff[a] * dsgn;
      end
   end

   // Round to nearest, add back the target; a zero half-life passes the target.
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         v_rnd[a] = p_ff[a] + (PW'(1) <<< (FRAC_BITS - 1));
         q_rnd[a] = v_rnd[a] >>> FRAC_BITS;
         if (period_ff == '0) begin
            out_in[a] = tgt_ff[a];
         end else begin
            out_in[a] = tgt_ff[a] + q_rnd[a][VAL_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         mul_valid_ff <= exp_valid;
         out_valid_ff <= mul_valid_ff;
      end
      if (advance) begin
         for (int a = 0; a < 3; a++) begin
            p_ff[a]   <= p_in[a];
            tgt_ff[a] <= tgt[a];
            out_ff[a] <= out_in[a];
         end
      end
   end

   assign rsp_bus.valid = out_valid_ff;
   assign rsp_bus.out_x = out_ff[0];
   assign rsp_bus.out_y = out_ff[1];
   assign rsp_bus.out_z = out_ff[2];
endmodule
`default_nettype wire

// ===== dv/testbench.sv =====
module testbench;
   import hles_pkg::*;

   localparam int FRAC = 16;
   localparam int LATENCY = 24 + 2 * FRAC + 3;

   typedef struct {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
   } point_type;

   // Expected smoothed points, oldest first.
   class smoothing_scoreboard;
      point_type pending[$];
      int     mismatches;
      int     checked;

      // Floor square root of a 64-bit value.
      function logic [63:0] floor_sqrt(input logic [63:0] v);
         logic [63:0] rem;
         logic [63:0] res;
         logic [63:0] b;
         rem = v;
         res = '0;
         for (int i = 31; i >= 0; i--) begin
            b = 64'd1 << (2 * i);
            if (rem >= res + b) begin
               rem = rem - (res + b);
               res = (res >> 1) + b;
            end else begin
               res = res >> 1;
            end
         end
         return res;
      endfunction

      // Decay 2^(-elapsed/period) in Q1.16.
      function logic [63:0] decay(input logic [23:0] dt, input logic [31:0] hl);
         logic [63:0] ratio;
         logic [63:0] whole;
         logic [63:0] frac;
         logic [63:0] acc;
         logic [63:0] root;
         logic [63:0] sh;
         ratio = ({40'd0, dt} << FRAC) / {32'd0, hl};
         whole = ratio >> FRAC;
         frac = ratio & ((64'd1 << FRAC) - 1);
         acc = 64'd1 << 32;
         root = 64'd1 << 31;
         for (int k = 1; k <= FRAC; k++) begin
            root = floor_sqrt(root << 32);
            if (frac[FRAC - k])
               acc = (acc * root + (64'd1 << 31)) >> 32;
         end
         if (whole > 63) return 64'd0;
         sh = 64'd32 - FRAC + whole;
         if (sh > 63) return 64'd0;
         return (acc + (64'd1 << (sh - 1))) >> sh;
      endfunction

      // Pull one axis toward its target; rounding is floor after adding one half.
      function logic signed [31:0] blend(input logic signed [31:0] cur,
                                          input logic signed [31:0] tgt,
                                          input logic [63:0] d);
         logic signed [63:0] p;
         logic signed [63:0] q;
         p = (64'(cur) - 64'(tgt)) * $signed(d);
         q = (p + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
         return 32'(64'(tgt) + q);
      endfunction

      function void note_request(input point_type cur, input point_type tgt,
                                 input logic [23:0] dt, input logic [31:0] hl);
         point_type e;
         logic [63:0] d;
         if (hl == 0) begin
            e = tgt;
         end else begin
            d = decay(dt, hl);
            e.x = blend(cur.x, tgt.x, d);
            e.y = blend(cur.y, tgt.y, d);
            e.z = blend(cur.z, tgt.z, d);
         end
         pending.push_back(e);
      endfunction

      function void check_result(input point_type got);
         point_type e;
         checked++;
         if (pending.size() == 0) begin
            $error("result with no request outstanding");
            mismatches++;
            return;
         end
         e = pending.pop_front();
         if (got.x !== e.x) begin
            $error("out_x expected %0d got %0d", e.x, got.x);
            mismatches++;
         end
         if (got.y !== e.y) begin
            $error("out_y expected %0d got %0d", e.y, got.y);
            mismatches++;
         end
         if (got.z !== e.z) begin
            $error("out_z expected %0d got %0d", e.z, got.z);
            mismatches++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic csr_write_enable = 0;
   logic [31:0] csr_write_data = '0;
   logic [31:0] period_now = HL_RESET;
   logic rsp_enable = 0;
   smoothing_scoreboard board = new();

   hles_req_if req_bus();
   hles_rsp_if rsp_bus();

   half_life_exponential_smoother #(.FRAC_BITS(FRAC)) u_dut (
      .clock(clock),
      .reset(reset),
      .req_bus(req_bus.sink),
      .rsp_bus(rsp_bus.source),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data)
   );

   always #4 clock = ~clock;

   initial begin
      req_bus.valid = 0;
      req_bus.current_x = '0;
      req_bus.current_y = '0;
      req_bus.current_z = '0;
      req_bus.target_x = '0;
      req_bus.target_y = '0;
      req_bus.target_z = '0;
      req_bus.elapsed = '0;
      rsp_bus.ready = 0;
   end

   // Note requests and check results at the rising edge.
   always @(posedge clock) begin
      point_type cur;
      point_type tgt;
      point_type got;
      if (!reset && req_bus.valid && req_bus.ready) begin
         cur = '{req_bus.current_x, req_bus.current_y, req_bus.current_z};
         tgt = '{req_bus.target_x, req_bus.target_y, req_bus.target_z};
         board.note_request(cur, tgt, req_bus.elapsed, period_now);
      end
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got = '{rsp_bus.out_x, rsp_bus.out_y, rsp_bus.out_z};
         board.check_result(got);
      end
   end

   // Result side: a random stall after each accepted transfer, often none.
   always @(negedge clock) begin
      int stall;
      if (rsp_enable) begin
         if (rsp_bus.ready && rsp_bus.valid) begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 3);
            if (stall != 0) begin
               rsp_bus.ready <= 0;
               repeat (stall) @(negedge clock);
               rsp_bus.ready <= 1;
            end
         end else begin
            rsp_bus.ready <= 1;
         end
      end
   end

   task automatic write_period(input logic [31:0] hl);
      @(negedge clock);
      csr_write_enable <= 1;
      csr_write_data <= hl;
      period_now = hl;
      @(negedge clock);
      csr_write_enable <= 0;
   endtask

   task automatic drain();
      while (board.pending.size() != 0) @(negedge clock);
      repeat (LATENCY + 4) @(negedge clock);
   endtask

   // One request transfer after a random gap, or none when calm; valid stays high across back-to-back items.
   task automatic send(input point_type cur, input point_type tgt, input logic [23:0] dt,
                       input bit calm);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 3);
      if (gap != 0) begin
         req_bus.valid <= 0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid <= 1;
      req_bus.current_x <= cur.x;
      req_bus.current_y <= cur.y;
      req_bus.current_z <= cur.z;
      req_bus.target_x <= tgt.x;
      req_bus.target_y <= tgt.y;
      req_bus.target_z <= tgt.z;
      req_bus.elapsed <= dt;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic idle_sender();
      req_bus.valid <= 0;
      @(negedge clock);
   endtask

   function automatic logic [31:0] any_coord();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return $urandom_range(0, 2000) - 1000;
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [23:0] any_elapsed();
      case ($urandom_range(0, 5))
         0: return 24'd0;
         1: return 24'hff_ffff;
         2: return 24'($urandom_range(1, 300));
         default: return 24'($urandom());
      endcase
   endfunction

   initial begin
      point_type cur;
      point_type tgt;
      logic [31:0] settings[6];
      int sent;
      settings = '{32'd65536, 32'd1, 32'hffff_ffff, 32'd0, 32'd6554, 32'd0};
      repeat (4) @(negedge clock);
      reset <= 0;
      rsp_enable <= 1;

      // Directed: field extremes, zero and long steps, reset half-life.
      cur = '{32'h7fff_ffff, 32'h8000_0000, 32'd0};
      tgt = '{32'h8000_0000, 32'h7fff_ffff, 32'd5};
      send(cur, tgt, 24'd0, 0);
      send(cur, tgt, 24'hff_ffff, 0);
      send(cur, tgt, 24'd65536, 0);
      send(cur, tgt, 24'd32768, 1);
      send(tgt, cur, 24'd1, 1);
      cur = '{32'hffff_ffff, 32'd1, 32'h5555_5555};
      tgt = '{32'd0, 32'hffff_fffe, 32'haaaa_aaaa};
      send(cur, tgt, 24'haa_aaaa, 0);
      send(tgt, cur, 24'h55_5555, 0);
      idle_sender();
      drain();

      // Zero half-life and tiny half-life.
      write_period(32'd0);
      send(cur, tgt, 24'd100, 0);
      send(cur, tgt, 24'd0, 0);
      idle_sender();
      drain();
      write_period(32'd1);
      send(cur, tgt, 24'd0, 0);
      send(cur, tgt, 24'd1, 0);
      idle_sender();
      drain();

      // Random phases over several half-life settings.
      sent = 0;
      for (int ph = 0; ph < 6; ph++) begin
         write_period(ph == 5 ? $urandom() : settings[ph]);
         for (int i = 0; i < 340; i++) begin
            cur = '{any_coord(), any_coord(), any_coord()};
            tgt = '{any_coord(), any_coord(), any_coord()};
            send(cur, tgt, any_elapsed(), (i / 40) % 3 == 0);
            sent++;
            // Hold off until every result is back, once per phase.
            if (i == 170) begin
               req_bus.valid <= 0;
               while (board.pending.size() != 0) @(negedge clock);
            end
         end
         idle_sender();
         drain();
      end

      $display("Checked %0d results over %0d random requests and six half-life settings,",
               board.checked, sent);
      $display("including zero, minimum and maximum half-life and extreme time steps.");
      if (board.mismatches == 0 && board.pending.size() == 0)
         $display("testbench OK");
      else
         $display("testbench NOT OK");
      $finish;
   end

   initial begin
      #4000000;
      $display("testbench NOT OK");
      $finish;
   end
endmodule
